/* rtl/lsms_pkg.sv */
`timescale 1ns / 1ps

package lsms_pkg;

   // Widths of the stream fields and configuration registers.
   localparam int ANGLE_WIDTH = 18;
   localparam int DIST_WIDTH  = 16;
   localparam int CONF_WIDTH  = 8;
   localparam int HW_WIDTH    = 14;
   localparam int MINPT_WIDTH = 8;
   localparam int ALPHA_WIDTH = 16;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;

   localparam int NUM_SECTORS = 4;

   // Saturating per-sector point counter.
   localparam int COUNT_WIDTH = 8;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > MINPT_WIDTH) ? COUNT_WIDTH : MINPT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [DIST_WIDTH-1:0] SAFE_RESET_MM = 16'd1500;

   // Angle arithmetic is done in a signed word with headroom for the wrap and bounds.
   localparam int WIDE_ANGLE = 20;
   localparam logic signed [WIDE_ANGLE-1:0] FULL_TURN    = 20'sd36000;
   localparam logic signed [WIDE_ANGLE-1:0] CENTER_RIGHT = 20'sd9000;
   localparam logic signed [WIDE_ANGLE-1:0] CENTER_BACK  = 20'sd18000;
   localparam logic signed [WIDE_ANGLE-1:0] CENTER_LEFT  = 20'sd27000;

   // Register reset values.
   localparam logic [CONF_WIDTH-1:0]  CONF_THR_RESET   = 8'd40;
   localparam logic [HW_WIDTH-1:0]    HALF_WIDTH_RESET = 14'd5000;
   localparam logic [MINPT_WIDTH-1:0] MIN_POINTS_RESET = 8'd3;
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET      = 16'd58982;
   localparam logic [DIST_WIDTH-1:0]  CEILING_RESET    = 16'd4000;

   // Result queue.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_CONF_THR   = 3'd0,
      CSR_HALF_WIDTH = 3'd1,
      CSR_MIN_POINTS = 3'd2,
      CSR_ALPHA      = 3'd3,
      CSR_CEILING    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CONF_WIDTH-1:0]  conf_thr;
      logic [HW_WIDTH-1:0]    half_width;
      logic [MINPT_WIDTH-1:0] min_points;
      logic [ALPHA_WIDTH-1:0] alpha;
      logic [DIST_WIDTH-1:0]  ceiling;
   } cfg_type;

   // A classified point: hit is one-hot over the sectors, or zero when dropped.
   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic [NUM_SECTORS-1:0] hit;
      logic [DIST_WIDTH-1:0]  range_mm;
   } point_type;

   // End-of-scan snapshot of the per-sector minima and update enables.
   typedef struct packed {
      logic                                    valid;
      logic [NUM_SECTORS-1:0]                  upd;
      logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0]  minimum;
   } scan_type;

endpackage

/* rtl/lsms_classify.sv */
`timescale 1ns / 1ps

module lsms_classify
   import lsms_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [ANGLE_WIDTH-1:0] in_angle,
   input  logic [DIST_WIDTH-1:0]         in_dist,
   input  logic [CONF_WIDTH-1:0]         in_conf,
   input  logic                          in_last,
   input  cfg_type                       cfg,
   output point_type                     point_ff
);

   logic signed [WIDE_ANGLE-1:0] a_ext;
   logic signed [WIDE_ANGLE-1:0] a_pos;
   logic signed [WIDE_ANGLE-1:0] a_wrap;
   logic signed [WIDE_ANGLE-1:0] hw;
   logic                         keep;
   logic                         in_front;
   logic                         in_right;
   logic                         in_back;
   logic                         in_left;
   point_type                    point_in;

   always_comb begin
      a_ext  = WIDE_ANGLE'(in_angle);
      a_pos  = (a_ext < 0) ? a_ext + FULL_TURN : a_ext;
      a_wrap = (a_pos >= FULL_TURN) ? a_pos - FULL_TURN : a_pos;
      hw     = $signed(WIDE_ANGLE'(cfg.half_width));

      in_front = (a_wrap <= hw) || (a_wrap >= FULL_TURN - hw);
      in_right = (a_wrap >= CENTER_RIGHT - hw) && (a_wrap <= CENTER_RIGHT + hw);
      in_back  = (a_wrap >= CENTER_BACK - hw) && (a_wrap <= CENTER_BACK + hw);
      in_left  = (a_wrap >= CENTER_LEFT - hw) && (a_wrap <= CENTER_LEFT + hw);

      keep = (in_dist != '0) && (in_conf >= cfg.conf_thr);

      point_in.valid    = in_valid;
      point_in.last     = in_last;
      point_in.range_mm = in_dist;
      point_in.hit      = '0;
      // First match wins, in the order front, right, back, left.
      if (keep) begin
         if (in_front) begin
            point_in.hit[0] = 1'b1;
         end else if (in_right) begin
            point_in.hit[1] = 1'b1;
         end else if (in_back) begin
            point_in.hit[2] = 1'b1;
         end else if (in_left) begin
            point_in.hit[3] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      point_ff.last     <= point_in.last;
      point_ff.hit      <= point_in.hit;
      point_ff.range_mm <= point_in.range_mm;
      if (reset) begin
         point_ff.valid <= 1'b0;
      end else begin
         point_ff.valid <= point_in.valid;
      end
   end

endmodule

/* rtl/lsms_accum.sv */
`timescale 1ns / 1ps

module lsms_accum
   import lsms_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  point_type point,
   input  cfg_type   cfg,
   output scan_type  scan_ff
);

   logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0]  minima_ff;
   logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0]  minima_in;
   logic [NUM_SECTORS-1:0][COUNT_WIDTH-1:0] counts_ff;
   logic [NUM_SECTORS-1:0][COUNT_WIDTH-1:0] counts_in;
   logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0]  min_next;
   logic [NUM_SECTORS-1:0][COUNT_WIDTH-1:0] cnt_next;
   logic                                    end_of_scan;
   scan_type                                scan_in;

   always_comb begin
      end_of_scan = point.valid && point.last;
      for (int i = 0; i < NUM_SECTORS; i++) begin
         min_next[i] = minima_ff[i];
         cnt_next[i] = counts_ff[i];
         if (point.valid && point.hit[i]) begin
            if (point.range_mm < minima_ff[i]) begin
               min_next[i] = point.range_mm;
            end
            if (counts_ff[i] != COUNT_MAX) begin
               cnt_next[i] = counts_ff[i] + 1'b1;
            end
         end
         scan_in.minimum[i] = min_next[i];
         scan_in.upd[i]     = CMP_WIDTH'(cnt_next[i]) >= CMP_WIDTH'(cfg.min_points);
         // The scan-end point is folded in first, then the sector restarts.
         minima_in[i] = end_of_scan ? cfg.ceiling : min_next[i];
         counts_in[i] = end_of_scan ? '0 : cnt_next[i];
      end
      scan_in.valid = end_of_scan;
   end

   always_ff @(posedge clock) begin
      scan_ff.upd     <= scan_in.upd;
      scan_ff.minimum <= scan_in.minimum;
      if (reset) begin
         scan_ff.valid <= 1'b0;
         for (int i = 0; i < NUM_SECTORS; i++) begin
            minima_ff[i] <= CEILING_RESET;
            counts_ff[i] <= '0;
         end
      end else begin
         scan_ff.valid <= scan_in.valid;
         minima_ff     <= minima_in;
         counts_ff     <= counts_in;
      end
   end

endmodule

/* rtl/lsms_smooth.sv */
`timescale 1ns / 1ps

module lsms_smooth
   import lsms_pkg::*;
(
   input  logic                                   clock,
   input  logic                                   reset,
   input  scan_type                               scan,
   input  logic [ALPHA_WIDTH-1:0]                 alpha,
   output logic                                   push,
   output logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0] push_data
);

   localparam int DIFF_WIDTH = DIST_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * DIFF_WIDTH;

   logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0] smoothed_ff;
   logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0] smoothed_in;
   logic signed [DIFF_WIDTH-1:0]           diff;
   logic signed [DIFF_WIDTH-1:0]           alpha_s;
   logic signed [PROD_WIDTH-1:0]           prod;
   logic signed [PROD_WIDTH-1:0]           acc;

   // old*a + min*(1 - a) is computed as min + (old - min)*a, one multiply per sector.
   always_comb begin
      alpha_s = $signed({1'b0, alpha});
      diff    = '0;
      prod    = '0;
      acc     = '0;
      for (int i = 0; i < NUM_SECTORS; i++) begin
         diff = $signed({1'b0, smoothed_ff[i]}) - $signed({1'b0, scan.minimum[i]});
         prod = PROD_WIDTH'(diff) * PROD_WIDTH'(alpha_s);
         acc  = $signed({2'b00, scan.minimum[i], {DIST_WIDTH{1'b0}}}) + prod
                + $signed(PROD_WIDTH'(1) <<< (DIST_WIDTH - 1));
         // A zero minimum means no echo, so the sector keeps its value.
         if (scan.upd[i] && (scan.minimum[i] != '0)) begin
            push_data[i] = acc[2*DIST_WIDTH-1:DIST_WIDTH];
         end else begin
            push_data[i] = smoothed_ff[i];
         end
         smoothed_in[i] = scan.valid ? push_data[i] : smoothed_ff[i];
      end
      push = scan.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SECTORS; i++) begin
            smoothed_ff[i] <= SAFE_RESET_MM;
         end
      end else begin
         smoothed_ff <= smoothed_in;
      end
   end

endmodule

/* rtl/lsms_out_fifo.sv */
`timescale 1ns / 1ps

module lsms_out_fifo
   import lsms_pkg::*;
(
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   input  logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0] push_data,
   input  logic                                   pop_ready,
   output logic                                   pop_valid,
   output logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0] pop_data,
   output logic [FIFO_AW:0]                       count
);

   logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0] mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]                     wr_ptr_ff;
   logic [FIFO_AW-1:0]                     rd_ptr_ff;
   logic [FIFO_AW:0]                       count_ff;
   logic                                   pop;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* rtl/lidar_sector_min_smoother.sv */
`timescale 1ns / 1ps

// Nearest-obstacle tracker for four lidar sectors (front, right, back, left).
// Points enter on the req_ stream, one beat per point; req_tlast marks the last
// point of a revolution. Points with zero distance, low confidence or no sector
// are dropped; the rest fold into a per-sector running minimum and saturating
// point count. Each req_tlast beat produces exactly one rsp_ beat carrying the
// four smoothed distances; all other beats produce nothing. Throughput is one
// beat per clock while req_tready is high. A req_tlast beat's result passes the
// input register, classification register and per-sector accumulators, then the
// smoothing multiply writes the result queue. Results wait in an eight-entry
// queue when the receiver stalls. req_tready drops only when queued results plus
// end-of-scan beats still in the pipeline would fill it, so the point stream
// keeps moving through short output stalls. Registers are written through csr_
// while the block is idle, a user rule the block does not enforce; the ceiling
// takes effect at the next scan. Synchronous reset restores register defaults,
// sets every smoothed distance to 1500 mm, minima to 4000 mm and counts to zero.

module lidar_sector_min_smoother
   import lsms_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata: [17:0] angle_cdeg (signed), [33:18] distance_mm, [41:34] confidence,
   // [47:42] zero
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [47:0]               req_tdata,
   input  logic                      req_tlast,
   // rsp_tdata: [15:0] front_mm, [31:16] right_mm, [47:32] back_mm, [63:48] left_mm
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [63:0]               rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   // Input register stage.
   logic                          s1_valid_ff;
   logic signed [ANGLE_WIDTH-1:0] s1_angle_ff;
   logic [DIST_WIDTH-1:0]         s1_dist_ff;
   logic [CONF_WIDTH-1:0]         s1_conf_ff;
   logic                          s1_last_ff;
   logic                          req_accept;

   cfg_type                       cfg_ff;
   point_type                     point;
   scan_type                      scan;

   logic                                   push;
   logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0] push_data;
   logic [NUM_SECTORS-1:0][DIST_WIDTH-1:0] pop_data;
   logic [FIFO_AW:0]                       fifo_count;

   // End-of-scan beats in flight each hold a queue slot in reserve.
   logic [1:0]         inflight;
   logic [FIFO_AW+1:0] credit_sum;

   assign inflight   = 2'(s1_valid_ff && s1_last_ff) + 2'(point.valid && point.last)
                       + 2'(scan.valid);
   assign credit_sum = (FIFO_AW + 2)'(fifo_count) + (FIFO_AW + 2)'(inflight);
   assign req_tready = credit_sum < (FIFO_AW + 2)'(FIFO_DEPTH);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      s1_angle_ff <= $signed(req_tdata[17:0]);
      s1_dist_ff  <= req_tdata[33:18];
      s1_conf_ff  <= req_tdata[41:34];
      s1_last_ff  <= req_tlast;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_thr   <= CONF_THR_RESET;
         cfg_ff.half_width <= HALF_WIDTH_RESET;
         cfg_ff.min_points <= MIN_POINTS_RESET;
         cfg_ff.alpha      <= ALPHA_RESET;
         cfg_ff.ceiling    <= CEILING_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CONF_THR: begin
               cfg_ff.conf_thr <= csr_wdata[CONF_WIDTH-1:0];
            end
            CSR_HALF_WIDTH: begin
               cfg_ff.half_width <= csr_wdata[HW_WIDTH-1:0];
            end
            CSR_MIN_POINTS: begin
               cfg_ff.min_points <= csr_wdata[MINPT_WIDTH-1:0];
            end
            CSR_ALPHA: begin
               cfg_ff.alpha <= csr_wdata[ALPHA_WIDTH-1:0];
            end
            CSR_CEILING: begin
               cfg_ff.ceiling <= csr_wdata[DIST_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   lsms_classify u_classify (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_angle (s1_angle_ff),
      .in_dist  (s1_dist_ff),
      .in_conf  (s1_conf_ff),
      .in_last  (s1_last_ff),
      .cfg      (cfg_ff),
      .point_ff (point)
   );

   lsms_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .point   (point),
      .cfg     (cfg_ff),
      .scan_ff (scan)
   );

   lsms_smooth u_smooth (
      .clock     (clock),
      .reset     (reset),
      .scan      (scan),
      .alpha     (cfg_ff.alpha),
      .push      (push),
      .push_data (push_data)
   );

   lsms_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_data  (pop_data),
      .count     (fifo_count)
   );

   assign rsp_tdata = pop_data;

endmodule
